// ----- rtl/lls_pkg.sv -----
// Shared types, constants and helper functions for the lattice site-order decoder.
// Has no dependencies; every file but lls_stream_if refers to it by scoped names.
package lls_pkg;

    localparam int WORD_BITS      = 32;
    localparam int SIZE_BITS      = 25;
    localparam int SPLIT_BIT      = 24;
    localparam int NUM_LANES      = 4;
    localparam int CFG_IDX_BITS   = 3;
    localparam int DIMS_BITS      = 3;
    localparam int LEN_BITS       = 5;
    localparam int POS_BITS       = 7;
    localparam int DEF_MAX_DIMS   = 4;
    localparam int DEF_INDEX_BITS = 32;

    typedef logic [SIZE_BITS-1:0] t_size;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NUM_DIMS  = 3'd0,
        CFG_SIZE_DIM0 = 3'd1,
        CFG_SIZE_DIM1 = 3'd2,
        CFG_SIZE_DIM2 = 3'd3,
        CFG_SIZE_DIM3 = 3'd4
    } t_cfg_reg;

    // Effective extent of every dimension; unused dimensions hold one.
    typedef struct packed {
        t_size [NUM_LANES-1:0] dim;
    } t_geom;

    typedef struct packed {
        logic [WORD_BITS-1:0] padded_index;
    } t_in_item;

    typedef struct packed {
        logic                 inside_box;
        logic [WORD_BITS-1:0] site_number;
    } t_out_item;

    // Payload between pipeline stages. The coordinates still to be folded in sit
    // in x, with the next one always at the top position.
    typedef struct packed {
        logic                 in_box;
        t_size [2:0]          x;
        logic [WORD_BITS-1:0] acc;
    } t_pipe;

    // Number of significant bits of a size value.
    function automatic logic [LEN_BITS-1:0] bit_len(input t_size v);
        logic [LEN_BITS-1:0] len;
        len = '0;
        for (int i = 0; i < SIZE_BITS; i++) begin
            if (v[i]) begin
                len = LEN_BITS'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

// ----- rtl/lls_stream_if.sv -----
// Valid/ready stream interface used for the input and result channels.
// Depends on nothing; the payload type is given by the instantiating code.
interface lls_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/lls_decode.sv -----
// First pipeline stage: splits the padded index into per-dimension coordinates.
// Depends on lls_pkg for the geometry and pipeline payload types.
module lls_decode #(
    parameter int INDEX_BITS = lls_pkg::DEF_INDEX_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lls_pkg::WORD_BITS-1:0] i_index,
    input  lls_pkg::t_geom                i_geom,
    output logic                          o_valid,
    input  logic                          i_ready,
    output lls_pkg::t_pipe                o_data
);

    logic [INDEX_BITS-1:0]                    idx_used;
    logic [lls_pkg::WORD_BITS-1:0]            idx_word;
    lls_pkg::t_size                           dm1    [lls_pkg::NUM_LANES];
    logic [lls_pkg::NUM_LANES-1:0]            hi;
    logic [lls_pkg::LEN_BITS-1:0]             k      [lls_pkg::NUM_LANES];
    logic [lls_pkg::POS_BITS-1:0]             off    [lls_pkg::NUM_LANES];
    logic [lls_pkg::POS_BITS-1:0]             total;
    logic [lls_pkg::DIMS_BITS-1:0]            hcnt   [lls_pkg::NUM_LANES];
    logic [lls_pkg::WORD_BITS-1:0]            sh_lo  [lls_pkg::NUM_LANES];
    logic [lls_pkg::WORD_BITS-1:0]            sh_hi  [lls_pkg::NUM_LANES];
    logic [lls_pkg::SPLIT_BIT-1:0]            lmask  [lls_pkg::NUM_LANES];
    lls_pkg::t_size                           x      [lls_pkg::NUM_LANES];
    logic                                     in_box;
    logic                                     stage_ready;
    logic                                     r_valid;
    lls_pkg::t_pipe                           r_data;
    lls_pkg::t_pipe                           n_data;

    // Index bits at or above INDEX_BITS are ignored.
    assign idx_used = i_index[INDEX_BITS-1:0];
    assign idx_word = lls_pkg::WORD_BITS'(idx_used);

    always_comb begin
        for (int mu = 0; mu < lls_pkg::NUM_LANES; mu++) begin
            dm1[mu] = i_geom.dim[mu] - lls_pkg::t_size'(1);
            hi[mu]  = dm1[mu][lls_pkg::SPLIT_BIT];
            k[mu]   = hi[mu] ? lls_pkg::LEN_BITS'(lls_pkg::SPLIT_BIT) : lls_pkg::bit_len(dm1[mu]);
        end

        // Low bits are handed out dimension by dimension; the bit above the split
        // position is handed out afterwards, one per dimension that needs it.
        off[0]  = '0;
        hcnt[0] = '0;
        for (int mu = 1; mu < lls_pkg::NUM_LANES; mu++) begin
            off[mu]  = off[mu-1] + lls_pkg::POS_BITS'(k[mu-1]);
            hcnt[mu] = hcnt[mu-1] + lls_pkg::DIMS_BITS'(hi[mu-1]);
        end
        total = off[lls_pkg::NUM_LANES-1] + lls_pkg::POS_BITS'(k[lls_pkg::NUM_LANES-1]);

        in_box = 1'b1;
        for (int mu = 0; mu < lls_pkg::NUM_LANES; mu++) begin
            sh_lo[mu] = idx_word >> off[mu];
            sh_hi[mu] = idx_word >> (total + lls_pkg::POS_BITS'(hcnt[mu]));
            lmask[mu] = ~({lls_pkg::SPLIT_BIT{1'b1}} << k[mu]);
            x[mu]     = {hi[mu] & sh_hi[mu][0], sh_lo[mu][lls_pkg::SPLIT_BIT-1:0] & lmask[mu]};
            if (x[mu] >= i_geom.dim[mu]) begin
                in_box = 1'b0;
            end
        end

        n_data.in_box = in_box;
        n_data.x[2]   = x[2];
        n_data.x[1]   = x[1];
        n_data.x[0]   = x[0];
        n_data.acc    = lls_pkg::WORD_BITS'(x[3]);
    end

    assign stage_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = stage_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/lls_mac_stage.sv -----
// One multiply-accumulate pipeline stage of the site-number fold (acc = x + d * acc).
// Depends on lls_pkg for the pipeline payload type.
module lls_mac_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  lls_pkg::t_pipe i_data,
    input  lls_pkg::t_size i_dim,
    output logic           o_valid,
    input  logic           i_ready,
    output lls_pkg::t_pipe o_data
);

    logic [lls_pkg::SIZE_BITS+lls_pkg::WORD_BITS-1:0] prod;
    logic                                             stage_ready;
    logic                                             r_valid;
    lls_pkg::t_pipe                                   r_data;
    lls_pkg::t_pipe                                   n_data;

    // The product is needed only modulo the word size.
    assign prod = i_dim * i_data.acc;

    always_comb begin
        n_data.in_box = i_data.in_box;
        n_data.x[2]   = i_data.x[1];
        n_data.x[1]   = i_data.x[0];
        n_data.x[0]   = '0;
        n_data.acc    = lls_pkg::WORD_BITS'(i_data.x[2]) + prod[lls_pkg::WORD_BITS-1:0];
    end

    assign stage_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (stage_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_ready = stage_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ----- rtl/lattice_lebesgue_site_order_core.sv -----
// Lattice site-order decoder: four-stage pipeline that maps a Lebesgue curve position
// in the power-of-two padded lattice to an inside flag and a lexicographic site number.
// Depends on lls_pkg, lls_stream_if, lls_decode and lls_mac_stage.
//
// Each input transaction carries one padded index and yields exactly one result
// transaction. The block takes a new transaction every clock cycle while i_in.ready
// is high. Acceptance loads the coordinate decode stage, and the transaction then
// moves through the three multiply-accumulate stages that fold the coordinates into
// the site number as x0 + d0*(x1 + d1*(x2 + d2*x3)). The last stage is the output
// register, so while a result waits on o_out the earlier stages keep filling; only
// when all four stages hold transactions does i_in.ready drop.
// Stalls propagate stage by stage, so a held result never blocks a stage that still
// has a bubble. Coordinates are rebuilt from the index as follows: for each
// dimension in turn the low 24 bits of its padded extent take consecutive index
// bits, and then the bit at position 24 of every dimension that needs it takes the
// next index bits in dimension order. A site outside the real box reports
// inside_box low and a site number of zero; site numbers wrap modulo 2^32.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_wdata: index 0 is the
// dimension count, indexes 1 to 4 the extents. A size of zero counts as one, as do
// all dimensions at or beyond the configured count (capped at MAX_DIMS), and writes
// to other indexes are dropped. Registers may only be changed while no transaction
// is in flight, since every stage reads them directly.
module lattice_lebesgue_site_order_core #(
    parameter int MAX_DIMS   = lls_pkg::DEF_MAX_DIMS,
    parameter int INDEX_BITS = lls_pkg::DEF_INDEX_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lls_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [lls_pkg::SIZE_BITS-1:0]    i_cfg_wdata,
    lls_stream_if.sink                       i_in,
    lls_stream_if.source                     o_out
);

    // Configuration registers.
    logic [lls_pkg::DIMS_BITS-1:0] r_num_dims;
    lls_pkg::t_size                r_size [lls_pkg::NUM_LANES];

    logic [lls_pkg::DIMS_BITS-1:0] eff_dims;
    lls_pkg::t_geom                geom;

    // Stage-to-stage handshakes and payloads.
    logic           dec_valid, dec_ready;
    lls_pkg::t_pipe dec_data;
    logic           ma_valid, ma_ready;
    lls_pkg::t_pipe ma_data;
    logic           mb_valid, mb_ready;
    lls_pkg::t_pipe mb_data;
    logic           mc_valid;
    lls_pkg::t_pipe mc_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims <= lls_pkg::DIMS_BITS'(lls_pkg::NUM_LANES);
            for (int mu = 0; mu < lls_pkg::NUM_LANES; mu++) begin
                r_size[mu] <= lls_pkg::t_size'(1);
            end
        end else if (i_cfg_we) begin
            case (lls_pkg::t_cfg_reg'(i_cfg_idx))
                lls_pkg::CFG_NUM_DIMS:  r_num_dims <= i_cfg_wdata[lls_pkg::DIMS_BITS-1:0];
                lls_pkg::CFG_SIZE_DIM0: r_size[0]  <= i_cfg_wdata;
                lls_pkg::CFG_SIZE_DIM1: r_size[1]  <= i_cfg_wdata;
                lls_pkg::CFG_SIZE_DIM2: r_size[2]  <= i_cfg_wdata;
                lls_pkg::CFG_SIZE_DIM3: r_size[3]  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective extents: dimensions that are unused or sized zero behave as size one.
    always_comb begin
        if (r_num_dims > lls_pkg::DIMS_BITS'(MAX_DIMS)) begin
            eff_dims = lls_pkg::DIMS_BITS'(MAX_DIMS);
        end else begin
            eff_dims = r_num_dims;
        end
        for (int mu = 0; mu < lls_pkg::NUM_LANES; mu++) begin
            if (lls_pkg::DIMS_BITS'(mu) < eff_dims && r_size[mu] != '0) begin
                geom.dim[mu] = r_size[mu];
            end else begin
                geom.dim[mu] = lls_pkg::t_size'(1);
            end
        end
    end

    lls_decode #(
        .INDEX_BITS (INDEX_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_index (i_in.data.padded_index),
        .i_geom  (geom),
        .o_valid (dec_valid),
        .i_ready (dec_ready),
        .o_data  (dec_data)
    );

    // Horner fold, innermost bracket first: dimension 2, then 1, then 0.
    lls_mac_stage u_mac_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dec_valid),
        .o_ready (dec_ready),
        .i_data  (dec_data),
        .i_dim   (geom.dim[2]),
        .o_valid (ma_valid),
        .i_ready (ma_ready),
        .o_data  (ma_data)
    );

    lls_mac_stage u_mac_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (ma_valid),
        .o_ready (ma_ready),
        .i_data  (ma_data),
        .i_dim   (geom.dim[1]),
        .o_valid (mb_valid),
        .i_ready (mb_ready),
        .o_data  (mb_data)
    );

    lls_mac_stage u_mac_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mb_valid),
        .o_ready (mb_ready),
        .i_data  (mb_data),
        .i_dim   (geom.dim[0]),
        .o_valid (mc_valid),
        .i_ready (o_out.ready),
        .o_data  (mc_data)
    );

    // Sites outside the box report a zero site number.
    assign o_out.valid            = mc_valid;
    assign o_out.data.inside_box  = mc_data.in_box;
    assign o_out.data.site_number = mc_data.in_box ? mc_data.acc : '0;

endmodule

// ----- rtl/lls_checker.sv -----
// Port-level checker for the lattice site-order decoder, bound to the top level.
// Depends on lls_pkg for the word width; sees only the top-level ports.
module lls_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_out_inside,
    input logic [lls_pkg::WORD_BITS-1:0] i_out_site
);

    logic [2:0] r_count;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Transactions accepted but not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + 3'(in_acc) - 3'(out_acc);
        end
    end

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_inside |-> i_out_site == '0)
        else $error("site number not zero for a site outside the box");

    a_empty_output_accepts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled although the output register is empty");

    a_occupancy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4 && (r_count != '0 || !i_out_valid))
        else $error("in-flight transaction count out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_inside)
            && $stable(i_out_site))
        else $error("stalled result changed");

endmodule

bind lattice_lebesgue_site_order_core lls_checker u_lls_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_inside (o_out.data.inside_box),
    .i_out_site   (o_out.data.site_number)
);
